// ===== hw/rtl/lsd_pkg.sv =====
// Shared types, constants and the digit lookup for the serial command decoder.
// No dependencies; every other file in this block imports it.
package lsd_pkg;

   localparam int FRAME_DIGITS_DEF = 5;

   localparam int WORD_W      = 10;
   localparam int CODE_W      = 5;
   localparam int DIGIT_W     = 4;
   localparam int EVENT_W     = 5;
   localparam int BCD_OUT_W   = 20;
   localparam int TOTAL_OUT_W = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   // Header 001 and footer 00 around the 5-bit code
   localparam logic [WORD_W-1:0] FRAME_MASK = 10'h383;
   localparam logic [WORD_W-1:0] FRAME_OK   = 10'h080;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE        = 5'd0,
      EV_PLAY        = 5'd1,
      EV_STEP_FWD    = 5'd2,
      EV_STEP_REV    = 5'd3,
      EV_PAUSE       = 5'd4,
      EV_AUDIO1      = 5'd5,
      EV_AUDIO2      = 5'd6,
      EV_SEARCH      = 5'd7,
      EV_BUSY        = 5'd8,
      EV_SEEK        = 5'd9,
      EV_DIGIT       = 5'd10,
      EV_NOSEEK      = 5'd11,
      EV_OVERFLOW    = 5'd12,
      EV_UNSUPPORTED = 5'd13,
      EV_UNKNOWN     = 5'd14,
      EV_BADFRAME    = 5'd15,
      EV_RESET       = 5'd16
   } lsd_event_type;

   typedef enum logic {
      ACT_WORD  = 1'b0,
      ACT_RESET = 1'b1
   } lsd_action_type;

   // Command codes
   localparam logic [CODE_W-1:0] CODE_FILLER   = 5'h00;
   localparam logic [CODE_W-1:0] CODE_PLAY     = 5'h14;
   localparam logic [CODE_W-1:0] CODE_STEP_FWD = 5'h04;
   localparam logic [CODE_W-1:0] CODE_STEP_REV = 5'h12;
   localparam logic [CODE_W-1:0] CODE_PAUSE    = 5'h0A;
   localparam logic [CODE_W-1:0] CODE_AUDIO1   = 5'h0E;
   localparam logic [CODE_W-1:0] CODE_AUDIO2   = 5'h16;
   localparam logic [CODE_W-1:0] CODE_SEEK     = 5'h1A;
   // Known commands that the player does not act on
   localparam logic [CODE_W-1:0] CODE_NS_H10   = 5'h10;
   localparam logic [CODE_W-1:0] CODE_NS_H08   = 5'h08;
   localparam logic [CODE_W-1:0] CODE_NS_H18   = 5'h18;
   localparam logic [CODE_W-1:0] CODE_NS_H0C   = 5'h0C;
   localparam logic [CODE_W-1:0] CODE_NS_H1C   = 5'h1C;
   localparam logic [CODE_W-1:0] CODE_NS_H02   = 5'h02;
   localparam logic [CODE_W-1:0] CODE_NS_H1E   = 5'h1E;
   localparam logic [CODE_W-1:0] CODE_NS_H06   = 5'h06;
   localparam logic [CODE_W-1:0] CODE_NS_H0B   = 5'h0B;

   typedef struct packed {
      lsd_action_type    action;
      logic [WORD_W-1:0] command_word;
      logic              player_searching;
   } lsd_req_type;

   typedef struct packed {
      logic [TOTAL_OUT_W-1:0] search_digit_total;
      logic [BCD_OUT_W-1:0]   search_frame_bcd;
      logic                   audio_right_muted;
      logic                   audio_left_muted;
      lsd_event_type          event_res;
   } lsd_rsp_type;

   typedef struct packed {
      logic               is_digit;
      logic [DIGIT_W-1:0] value;
   } lsd_digit_type;

   function automatic lsd_digit_type digit_of_code(input logic [CODE_W-1:0] code);
      lsd_digit_type d;
      d.is_digit = 1'b1;
      unique case (code)
         5'd1:    d.value = 4'd0;
         5'd3:    d.value = 4'd8;
         5'd5:    d.value = 4'd4;
         5'd9:    d.value = 4'd2;
         5'd13:   d.value = 4'd6;
         5'd17:   d.value = 4'd1;
         5'd19:   d.value = 4'd9;
         5'd21:   d.value = 4'd5;
         5'd25:   d.value = 4'd3;
         5'd29:   d.value = 4'd7;
         default: begin
            d.is_digit = 1'b0;
            d.value    = '0;
         end
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/lsd_req_reg.sv =====
// Input register for the command decoder: holds one request until the core takes it.
// Depends on lsd_pkg.
module lsd_req_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lsd_pkg::lsd_req_type in_item,
   output logic               hold_valid,
   output lsd_pkg::lsd_req_type hold_item,
   input  logic               advance
);
   import lsd_pkg::*;

   logic        valid_ff, valid_in;
   lsd_req_type item_ff,  item_in;

   // Refill in the same cycle the held request moves on
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

// ===== hw/rtl/lsd_core.sv =====
// Decode logic and player state: repeat filter, framing check, command decode,
// seek/digit entry and mute flags. Depends on lsd_pkg.
module lsd_core #(
   parameter int FRAME_DIGITS = lsd_pkg::FRAME_DIGITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lsd_pkg::lsd_req_type item,
   output lsd_pkg::lsd_rsp_type rsp
);
   import lsd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_DIGITS + 1);
   localparam int BCD_W = DIGIT_W * FRAME_DIGITS;

   logic [WORD_W-1:0] prev_word_ff,  prev_word_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              armed_ff,      armed_in;
   logic [CNT_W-1:0]  cnt_ff,        cnt_in;
   logic [BCD_W-1:0]  digits_ff,     digits_in;
   logic              left_ff,       left_in;
   logic              right_ff,      right_in;

   logic [WORD_W-1:0]      word;
   logic [CODE_W-1:0]      code;
   lsd_digit_type          dig;
   lsd_event_type          ev;
   logic [BCD_OUT_W-1:0]   bcd_out;
   logic [TOTAL_OUT_W-1:0] total_out;

   assign word = item.command_word;
   assign code = word[6:2];
   assign dig  = digit_of_code(code);

   always_comb begin
      prev_word_in  = prev_word_ff;
      prev_valid_in = prev_valid_ff;
      armed_in      = armed_ff;
      cnt_in        = cnt_ff;
      digits_in     = digits_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      ev            = EV_NONE;
      bcd_out       = '0;
      total_out     = '0;

      if (item.action == ACT_RESET) begin
         left_in  = 1'b0;
         right_in = 1'b0;
         ev       = EV_RESET;
      end else if (!prev_valid_ff || word != prev_word_ff) begin
         prev_word_in  = word;
         prev_valid_in = 1'b1;
         if ((word & FRAME_MASK) == FRAME_OK) begin
            if (dig.is_digit) begin
               if (!armed_ff) begin
                  ev = EV_NOSEEK;
               end else if (cnt_ff < CNT_W'(FRAME_DIGITS)) begin
                  // digits shift in at the bottom, so the first digit entered is the most significant
                  digits_in = BCD_W'({digits_ff, dig.value});
                  cnt_in    = cnt_ff + CNT_W'(1);
                  ev        = EV_DIGIT;
               end else begin
                  cnt_in    = '0;
                  digits_in = '0;
                  ev        = EV_OVERFLOW;
               end
            end else begin
               unique case (code)
                  CODE_PLAY:     ev = EV_PLAY;
                  CODE_STEP_FWD: ev = EV_STEP_FWD;
                  CODE_STEP_REV: ev = EV_STEP_REV;
                  CODE_PAUSE:    ev = EV_PAUSE;
                  CODE_AUDIO1: begin
                     left_in = !left_ff;
                     ev      = EV_AUDIO1;
                  end
                  CODE_AUDIO2: begin
                     right_in = !right_ff;
                     ev       = EV_AUDIO2;
                  end
                  CODE_SEEK: begin
                     if (!armed_ff) begin
                        armed_in = 1'b1;
                        ev       = EV_SEEK;
                     end else begin
                        ev = EV_SEEK;
                        if (cnt_ff != '0) begin
                           if (!item.player_searching) begin
                              bcd_out   = BCD_OUT_W'(digits_ff);
                              total_out = TOTAL_OUT_W'(cnt_ff);
                              ev        = EV_SEARCH;
                           end else begin
                              ev = EV_BUSY;
                           end
                        end
                        cnt_in    = '0;
                        digits_in = '0;
                     end
                  end
                  CODE_FILLER: ev = EV_NONE;
                  CODE_NS_H10, CODE_NS_H08, CODE_NS_H18, CODE_NS_H0C, CODE_NS_H1C,
                  CODE_NS_H02, CODE_NS_H1E, CODE_NS_H06, CODE_NS_H0B:
                     ev = EV_UNSUPPORTED;
                  default: ev = EV_UNKNOWN;
               endcase
            end
         end else if (word != '0) begin
            ev = EV_BADFRAME;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_word_ff  <= '0;
         prev_valid_ff <= 1'b0;
         armed_ff      <= 1'b0;
         cnt_ff        <= '0;
         digits_ff     <= '0;
         left_ff       <= 1'b0;
         right_ff      <= 1'b0;
      end else if (fire) begin
         prev_word_ff  <= prev_word_in;
         prev_valid_ff <= prev_valid_in;
         armed_ff      <= armed_in;
         cnt_ff        <= cnt_in;
         digits_ff     <= digits_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
      end
   end

   assign rsp.event_res          = ev;
   assign rsp.audio_left_muted   = left_in;
   assign rsp.audio_right_muted  = right_in;
   assign rsp.search_frame_bcd   = bcd_out;
   assign rsp.search_digit_total = total_out;

endmodule

// ===== hw/rtl/lsd_rsp_reg.sv =====
// Result register for the command decoder: holds one result until the sink takes it.
// Depends on lsd_pkg.
module lsd_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lsd_pkg::lsd_rsp_type rsp_in,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lsd_pkg::lsd_rsp_type out_item
);
   import lsd_pkg::*;

   logic        valid_ff, valid_in;
   lsd_rsp_type item_ff,  item_in;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = rsp_in;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/laserdisc_serial_command_decoder.sv =====
// Top level of the serial command decoder: request register, decode core, result register.
// Depends on lsd_pkg, lsd_req_reg, lsd_core and lsd_rsp_reg.
//
// Takes one request per clock while the sink keeps up and gives one result per request,
// in order. A request is captured in the input register, then decoded and applied to
// the player state as it moves into the result register, from which the sink takes it
// when ready. Sustained rate is one request per cycle; it is set only by how fast the
// sink takes results, since the input register refills in the same cycle the result
// register frees up. No clearing pass after reset.
module laserdisc_serial_command_decoder #(
   parameter int FRAME_DIGITS = lsd_pkg::FRAME_DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] command_word, [10] player_searching, [15:11] zero
   input  logic [lsd_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] event_res, [5] audio_left_muted, [6] audio_right_muted,
   // [26:7] search_frame_bcd, [29:27] search_digit_total, [31:30] zero
   output logic [lsd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lsd_pkg::*;

   lsd_req_type in_item, hold_item;
   lsd_rsp_type core_rsp, out_item;
   logic        hold_valid, advance, fire;

   assign in_item.action           = lsd_action_type'(req_tuser);
   assign in_item.command_word     = req_tdata[WORD_W-1:0];
   assign in_item.player_searching = req_tdata[WORD_W];

   assign fire = hold_valid && advance;

   lsd_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .advance    (advance)
   );

   lsd_core #(
      .FRAME_DIGITS (FRAME_DIGITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (hold_item),
      .rsp   (core_rsp)
   );

   lsd_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .rsp_in    (core_rsp),
      .free      (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {2'b00, out_item};

endmodule

// ===== hw/rtl/lsd_checker.sv =====
// Port-level checks for the serial command decoder, bound to the top level.
// Depends on lsd_pkg and laserdisc_serial_command_decoder.
module lsd_port_checks (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lsd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lsd_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With the result register empty the input side must not stall
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // A player reset request passes to the output with both channels unmuted when the sink is ready
   a_reset_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) ##1 rsp_tready |=>
         rsp_tvalid && rsp_tdata[4:0] == EV_RESET && rsp_tdata[6:5] == 2'b00)
      else $error("player reset result wrong or late");

endmodule

bind laserdisc_serial_command_decoder lsd_port_checks u_lsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
